/* rtl/sid_pkg.sv */
package sid_pkg;

  // Operand and result width of the divider.
  localparam int unsigned DATA_WIDTH = 32;
  // Width of the quotient bit counter, which indexes DATA_WIDTH steps.
  localparam int unsigned CNT_WIDTH  = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture operands and form their magnitudes
    logic step;    // one restoring shift-subtract step
    logic finish;  // apply quotient sign and special cases, fill the result registers
  } dp_cmd_t;

  // Two's complement magnitude, read as an unsigned word.
  function automatic word_t magnitude(word_t v);
    word_t m;
    m = v[DATA_WIDTH-1] ? (~v + word_t'(1)) : v;
    return m;
  endfunction

endpackage

/* rtl/sid_if.sv */
interface sid_in_if import sid_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t numerator;
  word_t denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface sid_out_if import sid_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t quotient;
  word_t leftover;

  modport source (output valid, output quotient, output leftover, input ready);
  modport sink   (input valid, input quotient, input leftover, output ready);
endinterface

/* rtl/sid_datapath.sv */
module sid_datapath import sid_pkg::*; (
  input  logic    clk_i,
  input  dp_cmd_t cmd_i,
  input  word_t   numerator_i,
  input  word_t   denominator_i,
  output word_t   quotient_o,
  output word_t   leftover_o
);

  word_t                 num_q, num_d;
  word_t                 div_q, div_d;
  word_t                 quo_q, quo_d;
  word_t                 rem_q, rem_d;
  logic                  neg_q, neg_d;
  word_t                 res_quo_q, res_quo_d;
  word_t                 res_rem_q, res_rem_d;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   trial;

  // Partial remainder shifted left by one with the next dividend bit appended.
  assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, div_q};

  always_comb begin
    num_d     = num_q;
    div_d     = div_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    neg_d     = neg_q;
    res_quo_d = res_quo_q;
    res_rem_d = res_rem_q;
    if (cmd_i.load) begin
      num_d = numerator_i;
      div_d = magnitude(denominator_i);
      quo_d = magnitude(numerator_i);
      rem_d = '0;
      neg_d = numerator_i[DATA_WIDTH-1] ^ denominator_i[DATA_WIDTH-1];
    end
    if (cmd_i.step) begin
      if (!trial[DATA_WIDTH]) begin
        rem_d = trial[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      // A zero divisor or a dividend whose magnitude is below the divisor's returns the
      // signed dividend unchanged with a zero quotient.
      if ((div_q == '0) || (quo_q == '0)) begin
        res_quo_d = '0;
        res_rem_d = num_q;
      end else begin
        res_quo_d = neg_q ? (~quo_q + word_t'(1)) : quo_q;
        res_rem_d = rem_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    div_q     <= div_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    neg_q     <= neg_d;
    res_quo_q <= res_quo_d;
    res_rem_q <= res_rem_d;
  end

  assign quotient_o = res_quo_q;
  assign leftover_o = res_rem_q;

endmodule

/* rtl/sid_controller.sv */
module sid_controller import sid_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StBusy  = 2'd1;
  localparam logic [1:0] StFixup = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StBusy;
        end
      end
      StBusy: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + CNT_WIDTH'(1);
        if (cnt_q == CNT_WIDTH'(DATA_WIDTH - 1)) begin
          state_d = StFixup;
        end
      end
      StFixup: begin
        cmd_o.finish = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* rtl/signed_integer_divider.sv */
// Signed integer divider, one transaction at a time.
// The result is held valid until it is taken, and a new transaction is accepted only
// after that. The radix-2 restoring loop resolves one quotient bit per cycle.
// Reset: rst_ni is asynchronous and active low; it returns the controller to idle.
module signed_integer_divider import sid_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  sid_in_if.sink  in_i,
  sid_out_if.source out_o
);

  // The controller sequences the work: it takes one input transaction, runs
  // DATA_WIDTH shift-subtract steps in the datapath, then a fix-up step
  // that applies the quotient sign and the special cases, and finally holds
  // the result valid until the output transaction completes.
  dp_cmd_t cmd;

  sid_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // The datapath divides the operand magnitudes. A zero divisor, and a
  // dividend whose magnitude is below the divisor's, both leave a zero
  // quotient, and then the signed dividend is returned as the remainder.
  // The most negative value divided by minus one wraps back to itself.
  sid_datapath u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .numerator_i   (in_i.numerator),
    .denominator_i (in_i.denominator),
    .quotient_o    (out_o.quotient),
    .leftover_o    (out_o.leftover)
  );

endmodule

/* rtl/sid_checker.sv */
module sid_assertions import sid_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input word_t quotient_i,
  input word_t leftover_i
);

  // The block never offers a result while it can take a new transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result is pending");

  // Each accepted input transaction leads to a valid result once the shift-subtract steps and the fix-up step have run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> ##(DATA_WIDTH + 2) out_valid_i)
    else $error("result did not appear after the expected latency");

  // Once a result is taken, the block is ready for the next transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) |=> in_ready_i)
    else $error("not ready after the result was taken");

  // A pending result stays with stable payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(quotient_i) && $stable(leftover_i)))
    else $error("pending result dropped or changed");

endmodule

bind signed_integer_divider sid_assertions u_sid_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .quotient_i  (out_o.quotient),
  .leftover_i  (out_o.leftover)
);
